// ===== rtl/cde_pkg.sv =====
// ----------------------------------------------------------------------------
// cde_pkg
// Shared widths, constants and the sequencer state type of the categorical
// dictionary encoder.
// ----------------------------------------------------------------------------
package cde_pkg;

	localparam int COL_W       = 6;
	localparam int VAL_W       = 32;
	localparam int CODE_W      = 16;
	localparam int NC_W        = 7;
	localparam int KEY_W       = COL_W + VAL_W;

	localparam int DEF_TABLE_DEPTH = 1024;

	// stream word layouts
	localparam int IN_TDATA_W  = 40;   // column, value_bits, pad
	localparam int OUT_TDATA_W = 56;   // field_index, feature_code, out_value_bits, pad
	localparam int OUT_TUSER_W = 2;    // is_numeric, table_full
	localparam int OUT_PAY_W   = COL_W + CODE_W + VAL_W;

	localparam logic [VAL_W-1:0] ONE_BITS = 32'h3F80_0000;

	// single precision exponent landmarks
	localparam logic [7:0] EXP_ONE = 8'd127;  // |x| >= 1.0
	localparam logic [7:0] EXP_INT = 8'd150;  // mantissa lsb weighs 1
	localparam logic [7:0] EXP_SAT = 8'd158;  // |x| >= 2^31
	localparam logic [7:0] EXP_MAX = 8'hFF;   // inf / nan

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CONV,
		ST_PROBE,
		ST_CMP
	} state_t;

endpackage

// ===== rtl/categorical_dictionary_encoder.sv =====
// ----------------------------------------------------------------------------
// categorical_dictionary_encoder
// Maps table cells to feature codes: numeric columns pass through, categorical
// (column, integer value) keys get codes from a hashed on-chip dictionary.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one cell per word (column, value_bits). m_axis returns one
//   word per cell; tuser flags numeric pass-through and dictionary overflow.
//   cfg_wr_en/cfg_wr_data load numeric_count; write only while idle.
// Throughput:
//   Numeric cell: result registered on accept, one cell per cycle unless stalled.
//   Categorical cell: accept, float-to-int + hash, table read, compare/insert,
//   with one more table read and compare per extra linear probe after a
//   hash collision; a miss on a full table probes every entry. No new cell is
//   accepted until the lookup ends: the RAM reads and compares one entry at a time.
// Reset:
//   Dictionary is emptied after arst_n releases: a clearing pass writes all
//   TABLE_DEPTH entries with s_axis_tready low; config writes are taken
//   throughout.
// Back-pressure:
//   The result holds in the output register while m_axis_tready is low; a new
//   cell is accepted only when idle and that register is empty or being drained.
// ----------------------------------------------------------------------------
module categorical_dictionary_encoder #(
	parameter int TABLE_DEPTH = cde_pkg::DEF_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [cde_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [5:0] column, [37:6] value_bits

	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [cde_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [5:0] field_index,
	                                                        // [21:6] feature_code,
	                                                        // [53:22] out_value_bits
	output logic [cde_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // [0] is_numeric, [1] table_full

	input  logic                             cfg_wr_en,
	input  logic [cde_pkg::NC_W-1:0]         cfg_wr_data    // numeric_count
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int UW    = $clog2(TABLE_DEPTH + 1);
	localparam int MEM_W = 1 + cde_pkg::KEY_W + cde_pkg::CODE_W;
	localparam int FOLDS = (cde_pkg::KEY_W + AW - 1) / AW;
	localparam int SUM_W = ((UW > cde_pkg::NC_W) ? UW : cde_pkg::NC_W) + 2;

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	cde_pkg::state_t state_q, nxt_state;

	logic [cde_pkg::COL_W-1:0]  s_col;
	logic [cde_pkg::VAL_W-1:0]  s_val;
	logic                       accept;
	logic                       s_is_num;

	logic [cde_pkg::COL_W-1:0]  col_q;
	logic [cde_pkg::VAL_W-1:0]  val_q;
	logic [cde_pkg::KEY_W-1:0]  key_q;
	logic [AW-1:0]              probe_q;
	logic [AW-1:0]              pcnt_q;
	logic [AW-1:0]              clr_q;
	logic [UW-1:0]              used_q;
	logic [cde_pkg::NC_W-1:0]   nc_q;
	logic [MEM_W-1:0]           rd_q;

	logic                        out_valid_q;
	logic [cde_pkg::COL_W-1:0]   out_col_q;
	logic [cde_pkg::CODE_W-1:0]  out_code_q;
	logic [cde_pkg::VAL_W-1:0]   out_val_q;
	logic                        out_num_q;
	logic                        out_full_q;

	// float to int32, truncating and saturating
	logic [7:0]                  expo;
	logic [22:0]                 mant;
	logic [7:0]                  sh_l;
	logic [7:0]                  sh_r;
	logic [31:0]                 mag_ext;
	logic [31:0]                 mag;
	logic [31:0]                 int_c;
	logic [cde_pkg::KEY_W-1:0]   key_c;

	logic [FOLDS*AW-1:0]         key_pad;
	logic [AW-1:0]               fold_c;
	logic [AW-1:0]               hash_c;

	logic                        rd_valid;
	logic [cde_pkg::KEY_W-1:0]   rd_key;
	logic [cde_pkg::CODE_W-1:0]  rd_code;
	logic [SUM_W-1:0]            code_sum;
	logic [cde_pkg::CODE_W-1:0]  new_code;
	logic [AW-1:0]               probe_nxt;

	logic [MEM_W-1:0]            mem [TABLE_DEPTH];
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [MEM_W-1:0]            mem_wdata;

	logic                        res_load;
	logic [cde_pkg::CODE_W-1:0]  res_code;
	logic                        res_full;
	logic                        ins;
	logic                        adv;

	assign s_col  = s_axis_tdata[cde_pkg::COL_W-1:0];
	assign s_val  = s_axis_tdata[cde_pkg::COL_W +: cde_pkg::VAL_W];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_is_num = ({1'b0, s_col} < nc_q);

	assign s_axis_tready = (state_q == cde_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);

	// ---- conversion and hash ----
	assign expo    = val_q[30:23];
	assign mant    = val_q[22:0];
	assign sh_l    = expo - cde_pkg::EXP_INT;
	assign sh_r    = cde_pkg::EXP_INT - expo;
	assign mag_ext = {8'h00, 1'b1, mant};
	assign mag     = (expo >= cde_pkg::EXP_INT) ? (mag_ext << sh_l[2:0])
	                                            : (mag_ext >> sh_r[4:0]);

	always_comb begin
		if (expo == cde_pkg::EXP_MAX && mant != 23'd0) begin
			int_c = 32'd0;
		end else if (expo < cde_pkg::EXP_ONE) begin
			int_c = 32'd0;
		end else if (expo >= cde_pkg::EXP_SAT) begin
			int_c = val_q[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			int_c = val_q[31] ? (32'd0 - mag) : mag;
		end
	end

	assign key_c   = {col_q, int_c};
	assign key_pad = (FOLDS*AW)'(key_c);

	always_comb begin
		fold_c = '0;
		for (int i = 0; i < FOLDS; i++) begin
			fold_c = fold_c ^ key_pad[i*AW +: AW];
		end
	end

	// fold may exceed the depth when it is not a power of two
	assign hash_c = ({1'b0, fold_c} >= (AW+1)'(TABLE_DEPTH)) ? (fold_c - AW'(TABLE_DEPTH))
	                                                         : fold_c;

	// ---- table word and code ----
	assign rd_valid  = rd_q[MEM_W-1];
	assign rd_key    = rd_q[cde_pkg::CODE_W +: cde_pkg::KEY_W];
	assign rd_code   = rd_q[cde_pkg::CODE_W-1:0];
	assign code_sum  = SUM_W'(nc_q) + SUM_W'(used_q) + SUM_W'(1);
	assign new_code  = cde_pkg::CODE_W'(code_sum);
	assign probe_nxt = (probe_q == LAST_IDX) ? '0 : probe_q + AW'(1);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cde_pkg::ST_CLEAR;
		end else begin
			state_q <= nxt_state;
		end
	end

	always_comb begin
		nxt_state = state_q;
		mem_we    = 1'b0;
		mem_waddr = probe_q;
		mem_wdata = {1'b1, key_q, new_code};
		res_load  = 1'b0;
		res_code  = '0;
		res_full  = 1'b0;
		ins       = 1'b0;
		adv       = 1'b0;
		case (state_q)
			cde_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == LAST_IDX) begin
					nxt_state = cde_pkg::ST_IDLE;
				end
			end
			cde_pkg::ST_IDLE: begin
				if (accept && !s_is_num) begin
					nxt_state = cde_pkg::ST_CONV;
				end
			end
			cde_pkg::ST_CONV: begin
				nxt_state = cde_pkg::ST_PROBE;
			end
			cde_pkg::ST_PROBE: begin
				nxt_state = cde_pkg::ST_CMP;
			end
			cde_pkg::ST_CMP: begin
				if (rd_valid && rd_key == key_q) begin
					res_load  = 1'b1;
					res_code  = rd_code;
					nxt_state = cde_pkg::ST_IDLE;
				end else if (!rd_valid) begin
					// empty slot ends the chain: key is new, table has room
					mem_we    = 1'b1;
					ins       = 1'b1;
					res_load  = 1'b1;
					res_code  = new_code;
					nxt_state = cde_pkg::ST_IDLE;
				end else if (pcnt_q == LAST_IDX) begin
					res_load  = 1'b1;
					res_full  = 1'b1;
					nxt_state = cde_pkg::ST_IDLE;
				end else begin
					adv       = 1'b1;
					nxt_state = cde_pkg::ST_PROBE;
				end
			end
			default: begin
				nxt_state = cde_pkg::ST_CLEAR;
			end
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			used_q      <= '0;
			nc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == cde_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ins) begin
				used_q <= used_q + UW'(1);
			end
			if (cfg_wr_en) begin
				nc_q <= cfg_wr_data;
			end
			if (res_load || (accept && s_is_num)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= s_col;
			val_q <= s_val;
		end
		if (state_q == cde_pkg::ST_CONV) begin
			key_q   <= key_c;
			probe_q <= hash_c;
			pcnt_q  <= '0;
		end else if (adv) begin
			probe_q <= probe_nxt;
			pcnt_q  <= pcnt_q + AW'(1);
		end
		if (accept && s_is_num) begin
			out_col_q  <= s_col;
			out_code_q <= cde_pkg::CODE_W'(s_col);
			out_val_q  <= s_val;
			out_num_q  <= 1'b1;
			out_full_q <= 1'b0;
		end else if (res_load) begin
			out_col_q  <= col_q;
			out_code_q <= res_code;
			out_val_q  <= cde_pkg::ONE_BITS;
			out_num_q  <= 1'b0;
			out_full_q <= res_full;
		end
	end

	// ---- dictionary RAM ----
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[probe_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = cde_pkg::OUT_TDATA_W'({out_val_q, out_code_q, out_col_q});
	assign m_axis_tuser  = {out_full_q, out_num_q};

endmodule

// ===== rtl/cde_checker.sv =====
// ----------------------------------------------------------------------------
// cde_checker
// Port-level checks on the dictionary encoder's result stream.
// ----------------------------------------------------------------------------
module cde_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [cde_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic [cde_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

	localparam int CODE_LSB = cde_pkg::COL_W;
	localparam int VAL_LSB  = cde_pkg::COL_W + cde_pkg::CODE_W;

	// stalled word must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("numeric word flagged as table full");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tdata[CODE_LSB +: cde_pkg::CODE_W] == '0)
		else $error("overflow word carries a code");

	a_cat_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata[VAL_LSB +: cde_pkg::VAL_W] == cde_pkg::ONE_BITS &&
			m_axis_tdata[cde_pkg::OUT_TDATA_W-1:cde_pkg::OUT_PAY_W] == '0)
		else $error("categorical word value is not 1.0");

endmodule

bind categorical_dictionary_encoder cde_checker u_cde_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/categorical_dictionary_encoder_test.sv =====
// ----------------------------------------------------------------------------
// categorical_dictionary_encoder_test
// Streams table cells through the encoder and checks every result word
// against a predictor that keeps its own dictionary of (column, integer
// value) keys. Covers numeric pass-through, float truncation corner cases,
// dictionary hits and misses across numeric_count changes, a completely
// filled dictionary, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module categorical_dictionary_encoder_test;

	localparam int QUIET_LIMIT = 20000;   // cycles with no word moving
	localparam int DICT_DEPTH  = cde_pkg::DEF_TABLE_DEPTH;

	localparam logic [cde_pkg::VAL_W-1:0] SPECIAL_VALUES [13] = '{
		32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
		32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
		32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF, 32'h7F7F_FFFF,
		32'h0000_0001
	};

	typedef struct packed {
		logic [cde_pkg::COL_W-1:0]  field_index;
		logic [cde_pkg::CODE_W-1:0] feature_code;
		logic [cde_pkg::VAL_W-1:0]  out_value_bits;
		logic                       is_numeric;
		logic                       table_full;
	} cell_result_t;

	class encode_scoreboard;
		logic [cde_pkg::CODE_W-1:0] code_of_key [logic [cde_pkg::KEY_W-1:0]];
		int unsigned                used;
		logic [cde_pkg::NC_W-1:0]   numeric_count;
		cell_result_t               expected_words [$];
		int unsigned                mismatches;

		function new();
			used = 0;
			numeric_count = '0;
			mismatches = 0;
		endfunction

		// float to int32, toward zero, saturating; NaN gives zero
		function logic [cde_pkg::VAL_W-1:0] trunc_toward_zero(
			logic [cde_pkg::VAL_W-1:0] b);
			logic [7:0]                ex;
			logic [cde_pkg::VAL_W-1:0] mag;
			ex = b[30:23];
			if (ex == cde_pkg::EXP_MAX && b[22:0] != '0)
				return '0;
			if (ex < cde_pkg::EXP_ONE)
				return '0;
			if (ex >= cde_pkg::EXP_SAT)
				return b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			mag = {8'd0, 1'b1, b[22:0]};
			if (ex >= cde_pkg::EXP_INT)
				mag = mag << (ex - cde_pkg::EXP_INT);
			else
				mag = mag >> (cde_pkg::EXP_INT - ex);
			return b[31] ? -mag : mag;
		endfunction

		function void note_cell(logic [cde_pkg::COL_W-1:0] col,
		                        logic [cde_pkg::VAL_W-1:0] vbits);
			cell_result_t              r;
			logic [cde_pkg::KEY_W-1:0] key;
			r.field_index    = col;
			r.feature_code   = '0;
			r.out_value_bits = cde_pkg::ONE_BITS;
			r.is_numeric     = 1'b0;
			r.table_full     = 1'b0;
			if (col < numeric_count) begin
				r.feature_code   = cde_pkg::CODE_W'(col);
				r.out_value_bits = vbits;
				r.is_numeric     = 1'b1;
			end else begin
				key = {col, trunc_toward_zero(vbits)};
				if (code_of_key.exists(key)) begin
					r.feature_code = code_of_key[key];
				end else if (used < DICT_DEPTH) begin
					used++;
					r.feature_code = cde_pkg::CODE_W'(numeric_count + used);
					code_of_key[key] = r.feature_code;
				end else begin
					r.table_full = 1'b1;
				end
			end
			expected_words = {expected_words, r};
		endfunction

		function void check_word(logic [cde_pkg::OUT_TDATA_W-1:0] tdata,
		                         logic [cde_pkg::OUT_TUSER_W-1:0] tuser);
			cell_result_t e;
			cell_result_t got;
			got.field_index    = tdata[5:0];
			got.feature_code   = tdata[21:6];
			got.out_value_bits = tdata[53:22];
			got.is_numeric     = tuser[0];
			got.table_full     = tuser[1];
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: field %0d code %0d value %h num %b full %b",
						got.field_index, got.feature_code, got.out_value_bits,
						got.is_numeric, got.table_full);
				return;
			end
			e = expected_words.pop_front();
			if (got.field_index != e.field_index || got.feature_code != e.feature_code ||
			    got.out_value_bits != e.out_value_bits ||
			    got.is_numeric != e.is_numeric || got.table_full != e.table_full) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("word mismatch: exp field %0d code %0d value %h num %b full %b",
						e.field_index, e.feature_code, e.out_value_bits,
						e.is_numeric, e.table_full);
					$display("               got field %0d code %0d value %h num %b full %b",
						got.field_index, got.feature_code, got.out_value_bits,
						got.is_numeric, got.table_full);
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [cde_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [cde_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [cde_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
	logic                            cfg_wr_en = 1'b0;
	logic [cde_pkg::NC_W-1:0]        cfg_wr_data = '0;

	encode_scoreboard sb = new();

	logic [cde_pkg::KEY_W-1:0] sent_cells [$];   // {value_bits, column} of every cell sent
	bit               steady = 1'b0;    // no idling on either side
	bit               long_hold_req = 1'b0;
	bit               long_hold_done = 1'b0;
	int unsigned      hold_left = 0;
	int unsigned      quiet_cycles = 0;

	categorical_dictionary_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// output side: random stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("categorical_dictionary_encoder test failed");
				$finish;
			end
		end
	end

	task automatic send_cell(input logic [cde_pkg::COL_W-1:0] col,
	                         input logic [cde_pkg::VAL_W-1:0] vbits);
		if (!steady && $urandom_range(0, 99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, vbits, col};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_cell(col, vbits);
		sent_cells = {sent_cells, {vbits, col}};
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_numeric_count(input logic [cde_pkg::NC_W-1:0] nc);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= nc;
		sb.numeric_count = nc;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [cde_pkg::VAL_W-1:0] small_float();
		// |x| below 16, so truncation folds many patterns onto one key
		return {1'($urandom), 8'($urandom_range(120, 130)), 23'($urandom)};
	endfunction

	// mostly repeating keys from a few columns, the rest noise and corners
	task automatic send_pool_cell();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			send_cell(cde_pkg::COL_W'($urandom_range(0, 7) * 9), small_float());
		else if (pick < 92)
			send_cell(cde_pkg::COL_W'($urandom_range(0, 63)), $urandom);
		else
			send_cell(cde_pkg::COL_W'($urandom_range(0, 63)),
				SPECIAL_VALUES[$urandom_range(0, 12)]);
	endtask

	initial begin
		int unsigned pick;
		logic [cde_pkg::KEY_W-1:0] old_cell;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all columns numeric
		write_numeric_count(7'd64);
		send_cell(6'd0,  32'h0000_0000);
		send_cell(6'd63, 32'hFFFF_FFFF);
		send_cell(6'd0,  32'h7F80_0000);
		send_cell(6'd63, 32'h8000_0000);
		send_cell(6'd31, 32'h7FC0_0000);
		send_cell(6'd42, 32'h5555_5555);
		wait_drained();

		// all columns categorical: truncation corners and their hits
		write_numeric_count(7'd0);
		send_cell(6'd0,  32'h0000_0000);
		send_cell(6'd0,  32'h8000_0000);   // -0.0 hits 0
		send_cell(6'd0,  32'h7FC0_0000);   // NaN hits 0
		send_cell(6'd63, 32'h3F80_0000);
		send_cell(6'd63, 32'h3FC0_0000);   // 1.5 hits 1
		send_cell(6'd63, 32'hBF80_0000);
		send_cell(6'd63, 32'h7F80_0000);   // +inf saturates
		send_cell(6'd63, 32'h4F00_0000);   // 2^31 saturates, hit
		send_cell(6'd63, 32'hFF80_0000);
		send_cell(6'd63, 32'hCF00_0000);   // -2^31 exact, hit
		send_cell(6'd63, 32'h4EFF_FFFF);
		send_cell(6'd63, 32'h7F7F_FFFF);
		send_cell(6'd63, 32'h0000_0001);   // denormal
		send_cell(6'd63, 32'h4B00_0001);
		send_cell(6'd63, 32'hC070_0000);   // -3.75 -> -3
		send_cell(6'd63, 32'hFFFF_FFFF);   // negative NaN hits 0
		wait_drained();

		// numeric/categorical boundary; old codes survive the change
		write_numeric_count(7'd5);
		send_cell(6'd4,  32'h3F80_0000);
		send_cell(6'd5,  32'h3F80_0000);
		send_cell(6'd63, 32'h3F80_0000);
		wait_drained();

		// numeric stream with one long output stall
		write_numeric_count(7'd64);
		long_hold_req = 1'b1;
		repeat (150) send_cell(cde_pkg::COL_W'($urandom), $urandom);
		wait_drained();

		write_numeric_count(7'd0);
		repeat (450) send_pool_cell();
		wait_drained();

		// no idling through this phase
		write_numeric_count(cde_pkg::NC_W'($urandom_range(1, 63)));
		steady = 1'b1;
		repeat (450) send_pool_cell();
		wait_drained();
		steady = 1'b0;

		// register beyond the column range: everything numeric
		write_numeric_count(7'd127);
		repeat (100) send_cell(cde_pkg::COL_W'($urandom), $urandom);
		wait_drained();

		// fill the dictionary with fresh keys, then work on a full table
		write_numeric_count(7'd1);
		while (sb.used < DICT_DEPTH)
			send_cell(cde_pkg::COL_W'($urandom_range(1, 63)),
				{1'($urandom), 8'($urandom_range(150, 157)), 23'($urandom)});
		repeat (80) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				old_cell = sent_cells[$urandom_range(0, sent_cells.size() - 1)];
				send_cell(old_cell[cde_pkg::COL_W-1:0],
					old_cell[cde_pkg::KEY_W-1:cde_pkg::COL_W]);
			end else if (pick < 80) begin
				send_cell(cde_pkg::COL_W'($urandom_range(1, 63)), $urandom);
			end else begin
				send_cell(6'd0, $urandom);
			end
		end
		wait_drained();

		repeat (50) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d expected words never arrived", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("categorical_dictionary_encoder test passed");
		end else begin
			$display("categorical_dictionary_encoder test failed");
		end
		$finish;
	end

endmodule
